>>> rtl/core/mlp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared sizes, codes, types and address helpers for the ReLU MLP engine.
// ----------------------------------------------------------------------------
package mlp_pkg;

  // Network shape and number format.
  localparam int NUM_INPUTS   = 9;
  localparam int HIDDEN_WIDTH = 50;
  localparam int NUM_OUTPUTS  = 2;
  localparam int FRAC_BITS    = 16;

  localparam int LAST_LAYER = 4;

  // Field widths of the item channels and the accumulator.
  localparam int CMD_W    = 2;
  localparam int LAYER_W  = 3;
  localparam int ROWCOL_W = 6;
  localparam int VAL_W    = 32;
  localparam int OUT_W    = 31;
  localparam int ACC_W    = 64;

  // Weight store layout: layer 0, three hidden layers, then the output layer.
  localparam int W_L0_SIZE  = NUM_INPUTS * HIDDEN_WIDTH;
  localparam int W_HID_SIZE = HIDDEN_WIDTH * HIDDEN_WIDTH;
  localparam int W_OUT_BASE = W_L0_SIZE + 3 * W_HID_SIZE;
  localparam int W_TOTAL    = W_OUT_BASE + HIDDEN_WIDTH * NUM_OUTPUTS;
  localparam int B_TOTAL    = LAST_LAYER * HIDDEN_WIDTH + NUM_OUTPUTS;
  localparam int ACT_DEPTH  = 2 * HIDDEN_WIDTH;

  localparam int WA_W = $clog2(W_TOTAL);
  localparam int BA_W = $clog2(B_TOTAL);
  localparam int AA_W = $clog2(ACT_DEPTH);

  localparam int MAX_FAN = (HIDDEN_WIDTH > NUM_INPUTS) ? HIDDEN_WIDTH : NUM_INPUTS;
  localparam int IDX_W   = (MAX_FAN > 1) ? $clog2(MAX_FAN) : 1;
  localparam int FEAT_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WEIGHT  = 2'd0,
    CMD_BIAS    = 2'd1,
    CMD_FEATURE = 2'd2
  } cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MAC,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               acc_clr;
    logic               bias_rd;
    logic               mac_en;
    logic               res_wr;
    logic               out_load;
    logic [LAYER_W-1:0] layer;
    logic [IDX_W-1:0]   neuron;
    logic [IDX_W-1:0]   fan;
    logic [WA_W-1:0]    waddr;
  } dp_cmd_t;

  // First weight address of a layer.
  function automatic logic [WA_W-1:0] w_base(input logic [LAYER_W-1:0] l);
    logic [WA_W-1:0] b;
    case (l)
      3'd0:    b = '0;
      3'd1:    b = WA_W'(W_L0_SIZE);
      3'd2:    b = WA_W'(W_L0_SIZE + W_HID_SIZE);
      3'd3:    b = WA_W'(W_L0_SIZE + 2 * W_HID_SIZE);
      default: b = WA_W'(W_OUT_BASE);
    endcase
    return b;
  endfunction

  // Number of destination neurons of a layer, as a weight row stride.
  function automatic logic [WA_W-1:0] w_stride(input logic [LAYER_W-1:0] l);
    return (l == LAYER_W'(LAST_LAYER)) ? WA_W'(NUM_OUTPUTS) : WA_W'(HIDDEN_WIDTH);
  endfunction

  // Index of the last input of a layer.
  function automatic logic [IDX_W-1:0] last_fan(input logic [LAYER_W-1:0] l);
    return (l == '0) ? IDX_W'(NUM_INPUTS - 1) : IDX_W'(HIDDEN_WIDTH - 1);
  endfunction

  // Index of the last neuron of a layer.
  function automatic logic [IDX_W-1:0] last_neuron(input logic [LAYER_W-1:0] l);
    return (l == LAYER_W'(LAST_LAYER)) ? IDX_W'(NUM_OUTPUTS - 1) : IDX_W'(HIDDEN_WIDTH - 1);
  endfunction

endpackage

>>> rtl/core/mlp_if.sv
// ----------------------------------------------------------------------------
// mlp_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface mlp_in_if;
  logic                                valid;
  logic                                ready;
  logic [mlp_pkg::CMD_W-1:0]           cmd;
  logic [mlp_pkg::LAYER_W-1:0]         layer;
  logic [mlp_pkg::ROWCOL_W-1:0]        row;
  logic [mlp_pkg::ROWCOL_W-1:0]        col;
  logic signed [mlp_pkg::VAL_W-1:0]    value;
  logic                                last;

  modport source (output valid, cmd, layer, row, col, value, last, input ready);
  modport sink (input valid, cmd, layer, row, col, value, last, output ready);
endinterface

interface mlp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mlp_pkg::OUT_W-1:0]     logit_zero;
  logic [mlp_pkg::OUT_W-1:0]     logit_one;

  modport source (output valid, logit_zero, logit_one, input ready);
  modport sink (input valid, logit_zero, logit_one, output ready);
endinterface

>>> rtl/core/mlp_ram.sv
// ----------------------------------------------------------------------------
// mlp_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mlp_dp.sv
// ----------------------------------------------------------------------------
// mlp_dp
// Datapath: parameter stores, feature buffer, activation RAM and one MAC.
// ----------------------------------------------------------------------------
module mlp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ld_en,
  input  logic [mlp_pkg::CMD_W-1:0]           ld_cmd,
  input  logic [mlp_pkg::LAYER_W-1:0]         ld_layer,
  input  logic [mlp_pkg::ROWCOL_W-1:0]        ld_row,
  input  logic [mlp_pkg::ROWCOL_W-1:0]        ld_col,
  input  logic signed [mlp_pkg::VAL_W-1:0]    ld_value,
  input  mlp_pkg::dp_cmd_t                    cmd,
  output logic [mlp_pkg::OUT_W-1:0]           logit_zero,
  output logic [mlp_pkg::OUT_W-1:0]           logit_one
);

  logic                          w_ok;
  logic [mlp_pkg::WA_W-1:0]      w_ld_addr;
  logic                          b_ok;
  logic [mlp_pkg::BA_W-1:0]      b_ld_addr;
  logic [mlp_pkg::BA_W-1:0]      b_rd_addr;
  logic [mlp_pkg::B_TOTAL-1:0]   bias_vld;
  logic                          bias_vld_q;
  logic [mlp_pkg::VAL_W-1:0]     bias_rdata;
  logic [mlp_pkg::VAL_W-1:0]     w_rdata;
  logic [mlp_pkg::VAL_W-1:0]     act_rdata;
  logic [mlp_pkg::VAL_W-1:0]     feat [mlp_pkg::NUM_INPUTS];
  logic [mlp_pkg::VAL_W-1:0]     feat_q;
  logic                          src_feat;
  logic [mlp_pkg::AA_W-1:0]      act_raddr;
  logic [mlp_pkg::AA_W-1:0]      act_waddr;
  logic                          act_we;
  logic signed [mlp_pkg::VAL_W-1:0] x_val;
  logic signed [mlp_pkg::ACC_W-1:0] prod;
  logic signed [mlp_pkg::ACC_W-1:0] acc;
  logic signed [mlp_pkg::ACC_W-1:0] bias_ext;
  logic signed [mlp_pkg::ACC_W-1:0] sum;
  logic [mlp_pkg::OUT_W-1:0]     clamped;
  logic [mlp_pkg::OUT_W-1:0]     res0;
  logic [mlp_pkg::OUT_W-1:0]     res1;
  logic                          s1_valid;
  logic                          s2_valid;

  // Weight load address and range check.
  always_comb begin
    if (ld_layer == '0) begin
      w_ok = (ld_row < mlp_pkg::NUM_INPUTS) && (ld_col < mlp_pkg::HIDDEN_WIDTH);
    end else if (ld_layer < mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER)) begin
      w_ok = (ld_row < mlp_pkg::HIDDEN_WIDTH) && (ld_col < mlp_pkg::HIDDEN_WIDTH);
    end else if (ld_layer == mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER)) begin
      w_ok = (ld_row < mlp_pkg::HIDDEN_WIDTH) && (ld_col < mlp_pkg::NUM_OUTPUTS);
    end else begin
      w_ok = 1'b0;
    end
    w_ld_addr = mlp_pkg::w_base(ld_layer)
              + mlp_pkg::WA_W'(ld_row) * mlp_pkg::w_stride(ld_layer)
              + mlp_pkg::WA_W'(ld_col);
  end

  // Bias load address and range check; all layers share the same layout.
  always_comb begin
    if (ld_layer < mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER)) begin
      b_ok = ld_col < mlp_pkg::HIDDEN_WIDTH;
    end else if (ld_layer == mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER)) begin
      b_ok = ld_col < mlp_pkg::NUM_OUTPUTS;
    end else begin
      b_ok = 1'b0;
    end
    b_ld_addr = mlp_pkg::BA_W'(ld_layer) * mlp_pkg::BA_W'(mlp_pkg::HIDDEN_WIDTH)
              + mlp_pkg::BA_W'(ld_col);
    b_rd_addr = mlp_pkg::BA_W'(cmd.layer) * mlp_pkg::BA_W'(mlp_pkg::HIDDEN_WIDTH)
              + mlp_pkg::BA_W'(cmd.neuron);
  end

  mlp_ram #(.WIDTH(mlp_pkg::VAL_W), .DEPTH(mlp_pkg::W_TOTAL)) u_weight_ram (
    .clk   (clk),
    .we    (ld_en && (ld_cmd == mlp_pkg::CMD_WEIGHT) && w_ok),
    .waddr (w_ld_addr),
    .wdata (ld_value),
    .re    (cmd.mac_en),
    .raddr (cmd.waddr),
    .rdata (w_rdata)
  );

  mlp_ram #(.WIDTH(mlp_pkg::VAL_W), .DEPTH(mlp_pkg::B_TOTAL)) u_bias_ram (
    .clk   (clk),
    .we    (ld_en && (ld_cmd == mlp_pkg::CMD_BIAS) && b_ok),
    .waddr (b_ld_addr),
    .wdata (ld_value),
    .re    (cmd.bias_rd),
    .raddr (b_rd_addr),
    .rdata (bias_rdata)
  );

  // Bias valid bits: an unwritten bias reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_vld <= '0;
    end else if (ld_en && (ld_cmd == mlp_pkg::CMD_BIAS) && b_ok) begin
      bias_vld[b_ld_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bias_rd) begin
      bias_vld_q <= bias_vld[b_rd_addr];
    end
  end

  // Feature buffer write and registered read aligned with the RAMs.
  always_ff @(posedge clk) begin
    if (ld_en && (ld_cmd == mlp_pkg::CMD_FEATURE) && (ld_col < mlp_pkg::NUM_INPUTS)) begin
      feat[ld_col[mlp_pkg::FEAT_W-1:0]] <= ld_value;
    end
    if (cmd.mac_en) begin
      src_feat <= (cmd.layer == '0);
      if (cmd.fan < mlp_pkg::NUM_INPUTS) begin
        feat_q <= feat[cmd.fan[mlp_pkg::FEAT_W-1:0]];
      end
    end
  end

  // Odd layers read bank zero and write bank one; even layers the reverse.
  always_comb begin
    act_raddr = (cmd.layer[0] ? '0 : mlp_pkg::AA_W'(mlp_pkg::HIDDEN_WIDTH))
              + mlp_pkg::AA_W'(cmd.fan);
    act_waddr = (cmd.layer[0] ? mlp_pkg::AA_W'(mlp_pkg::HIDDEN_WIDTH) : '0)
              + mlp_pkg::AA_W'(cmd.neuron);
    act_we    = cmd.res_wr && (cmd.layer != mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER));
  end

  mlp_ram #(.WIDTH(mlp_pkg::VAL_W), .DEPTH(mlp_pkg::ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata ({1'b0, clamped}),
    .re    (cmd.mac_en),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  // Multiply stage, then floor-shift and accumulate.
  assign x_val = src_feat ? $signed(feat_q) : $signed(act_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_en;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prod <= $signed(w_rdata) * x_val;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + (prod >>> mlp_pkg::FRAC_BITS);
    end
  end

  // Bias add and clamp to the range of a 31-bit unsigned value.
  always_comb begin
    bias_ext = bias_vld_q ? mlp_pkg::ACC_W'($signed(bias_rdata)) : '0;
    sum      = acc + bias_ext;
    if (sum[mlp_pkg::ACC_W-1]) begin
      clamped = '0;
    end else if (|sum[mlp_pkg::ACC_W-2:mlp_pkg::OUT_W]) begin
      clamped = '1;
    end else begin
      clamped = sum[mlp_pkg::OUT_W-1:0];
    end
  end

  // Output layer results, staged until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.res_wr && (cmd.layer == mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER))) begin
      if (cmd.neuron == '0) begin
        res0 <= clamped;
      end else begin
        res1 <= clamped;
      end
    end
    if (cmd.out_load) begin
      logit_zero <= res0;
      logit_one  <= res1;
    end
  end

  // A neuron is finished only once its products have all been summed.
  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.res_wr |-> (!s1_valid && !s2_valid))
    else $error("result written while products still in flight");

  // Clearing the accumulator must never drop a pending product.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_clr |-> (!s2_valid && !cmd.mac_en))
    else $error("accumulator cleared during accumulation");

endmodule

>>> rtl/core/mlp_ctrl.sv
// ----------------------------------------------------------------------------
// mlp_ctrl
// Controller: walks layers, neurons and inputs, and owns the result handshake.
// ----------------------------------------------------------------------------
module mlp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_acc,
  input  logic [mlp_pkg::CMD_W-1:0]    in_cmd,
  input  logic                         in_last,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mlp_pkg::dp_cmd_t             cmd
);

  mlp_pkg::state_t                 state;
  mlp_pkg::state_t                 state_next;
  logic [mlp_pkg::LAYER_W-1:0]     layer;
  logic [mlp_pkg::LAYER_W-1:0]     layer_next;
  logic [mlp_pkg::IDX_W-1:0]       neuron;
  logic [mlp_pkg::IDX_W-1:0]       neuron_next;
  logic [mlp_pkg::IDX_W-1:0]       fan;
  logic [mlp_pkg::IDX_W-1:0]       fan_next;
  logic [mlp_pkg::WA_W-1:0]        waddr;
  logic [mlp_pkg::WA_W-1:0]        waddr_next;
  logic                            drain;
  logic                            drain_next;
  logic                            out_valid_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mlp_pkg::ST_IDLE;
      layer     <= '0;
      neuron    <= '0;
      fan       <= '0;
      waddr     <= '0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      layer     <= layer_next;
      neuron    <= neuron_next;
      fan       <= fan_next;
      waddr     <= waddr_next;
      drain     <= drain_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    layer_next     = layer;
    neuron_next    = neuron;
    fan_next       = fan;
    waddr_next     = waddr;
    drain_next     = drain;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.layer      = layer;
    cmd.neuron     = neuron;
    cmd.fan        = fan;
    cmd.waddr      = waddr;

    case (state)
      mlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && (in_cmd == mlp_pkg::CMD_FEATURE) && in_last) begin
          layer_next  = '0;
          neuron_next = '0;
          state_next  = mlp_pkg::ST_START;
        end
      end
      mlp_pkg::ST_START: begin
        cmd.acc_clr = 1'b1;
        cmd.bias_rd = 1'b1;
        fan_next    = '0;
        waddr_next  = mlp_pkg::w_base(layer) + mlp_pkg::WA_W'(neuron);
        state_next  = mlp_pkg::ST_MAC;
      end
      mlp_pkg::ST_MAC: begin
        cmd.mac_en = 1'b1;
        waddr_next = waddr + mlp_pkg::w_stride(layer);
        fan_next   = fan + 1'b1;
        if (fan == mlp_pkg::last_fan(layer)) begin
          drain_next = 1'b0;
          state_next = mlp_pkg::ST_DRAIN;
        end
      end
      mlp_pkg::ST_DRAIN: begin
        drain_next = 1'b1;
        if (drain) begin
          state_next = mlp_pkg::ST_WRITE;
        end
      end
      mlp_pkg::ST_WRITE: begin
        cmd.res_wr = 1'b1;
        if (neuron == mlp_pkg::last_neuron(layer)) begin
          neuron_next = '0;
          if (layer == mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER)) begin
            state_next = mlp_pkg::ST_DONE;
          end else begin
            layer_next = layer + 1'b1;
            state_next = mlp_pkg::ST_START;
          end
        end else begin
          neuron_next = neuron + 1'b1;
          state_next  = mlp_pkg::ST_START;
        end
      end
      mlp_pkg::ST_DONE: begin
        if (!out_valid) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = mlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mlp_pkg::ST_IDLE;
      end
    endcase
  end

  // A result appears only on the hand-off from the final layer.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mlp_pkg::ST_DONE))
    else $error("result raised outside the hand-off state");

  // The layer counter never passes the output layer while working.
  a_layer_range: assert property (@(posedge clk) disable iff (rst)
    (state != mlp_pkg::ST_IDLE) |-> (layer <= mlp_pkg::LAYER_W'(mlp_pkg::LAST_LAYER)))
    else $error("layer counter out of range");

endmodule

>>> rtl/core/mlp_relu_forward_inference.sv
// ----------------------------------------------------------------------------
// mlp_relu_forward_inference
// Fully connected ReLU network inference in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Weight, bias and feature items are accepted while the engine is idle. A
// feature item marked last starts inference, which runs on a single shared
// multiply-accumulate unit: each neuron takes a bias fetch, a product for
// each of its inputs, a pipeline drain and a write-back. New items are
// refused while inference runs; a finished result waits in the output
// register and does not block the next load.
module mlp_relu_forward_inference (
  input logic       clk,
  input logic       rst,
  mlp_in_if.sink    sample,
  mlp_out_if.source result
);

  mlp_pkg::dp_cmd_t dp_cmd;
  logic             sample_acc;
  logic             in_ready;

  assign sample.ready = in_ready;
  assign sample_acc   = sample.valid && in_ready;

  mlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_acc    (sample_acc),
    .in_cmd    (sample.cmd),
    .in_last   (sample.last),
    .in_ready  (in_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (dp_cmd)
  );

  mlp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ld_en      (sample_acc),
    .ld_cmd     (sample.cmd),
    .ld_layer   (sample.layer),
    .ld_row     (sample.row),
    .ld_col     (sample.col),
    .ld_value   (sample.value),
    .cmd        (dp_cmd),
    .logit_zero (result.logit_zero),
    .logit_one  (result.logit_one)
  );

endmodule
